>>> rtl/core/ttw_pkg.sv
package ttw_pkg;

    // Default screen geometry.
    localparam int DEF_COLS     = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STEP = 4;

    // Field widths of the stream payloads.
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int POS_W  = 7;
    localparam int IDX_W  = 11;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Character codes with special meaning.
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_ERR     = 8'd69;

    // Reset values of the attribute registers.
    localparam logic [ATTR_W-1:0] TEXT_COLOR_RST  = 8'd31;
    localparam logic [ATTR_W-1:0] ERROR_COLOR_RST = 8'd79;

    typedef enum logic [0:0] {
        REG_TEXT_COLOR  = 1'b0,
        REG_ERROR_COLOR = 1'b1
    } t_reg;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // latch the input beat
        logic exec;        // single-cell write, cursor update, capture result
        logic res_direct;  // present the freshly computed result
        logic out_load;    // load the output register
        logic copy;        // scroll copy step
        logic blank;       // blank one cell at the sweep counter
        logic sw_zero;     // sweep counter to zero
        logic sw_tail;     // sweep counter to start of last row
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd op;
        logic scroll;
        logic copy_last;
        logic fill_last;
    } t_stat;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [IDX_W-1:0]  cursor_index;
        logic              out_of_bounds;
        logic              scrolled;
    } t_res;

endpackage

>>> rtl/core/text_terminal_writer_core.sv
// Channel   Direction  Bits of tdata / tuser (lowest bit first)
// s_*       in         tdata: char_code 8, col 7, row 7, cell_index 11, pad to 40
//                      tuser: cmd 2, at_position 1
// m_*       out        tdata: cell_data 16, cursor_index 11, pad to 32
//                      tuser: out_of_bounds 1, scrolled 1
// i_cfg_*   in         index 0 text_color, index 1 error_color, 8-bit data
//
// A put, read or unused-command beat is taken, then executed: the single cell write or
// the return of the registered memory read. A scrolling put then copies each row up,
// flushes the last copy write and blanks the bottom row before the output load; a clear
// blanks every cell before the load (single memory write port).
// Synchronous active-low reset homes the cursor and restores the colors; cells stay
// undefined until written. Input is ready only between items; a stalled result waits.
module text_terminal_writer_core #(
    parameter int COLS     = ttw_pkg::DEF_COLS,
    parameter int ROWS     = ttw_pkg::DEF_ROWS,
    parameter int TAB_STEP = ttw_pkg::DEF_TAB_STEP
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [39:0]                s_tdata,  // char_code, col, row, cell_index
    input  logic [2:0]                 s_tuser,  // cmd, at_position
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,  // cell_data, cursor_index
    output logic [1:0]                 m_tuser,  // out_of_bounds, scrolled
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [ttw_pkg::ATTR_W-1:0] i_cfg_data
);
    import ttw_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;
    t_res  w_res;
    logic  w_out_free;

    // Output register: the finished result beat waits here for the sink.
    logic  r_m_tvalid;
    t_res  r_m_res;

    assign w_out_free = !r_m_tvalid || m_tready;

    ttw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_s_tready (s_tready),
        .o_ctl      (w_ctl)
    );

    ttw_datapath #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_cmd         (s_tuser[1:0]),
        .i_char_code   (s_tdata[7:0]),
        .i_at_position (s_tuser[2]),
        .i_col         (s_tdata[14:8]),
        .i_row         (s_tdata[21:15]),
        .i_cell_index  (s_tdata[32:22]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_stat        (w_stat),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_m_res <= w_res;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {5'b0, r_m_res.cursor_index, r_m_res.cell_data};
    assign m_tuser  = {r_m_res.scrolled, r_m_res.out_of_bounds};

endmodule

>>> rtl/core/ttw_ctrl.sv
module ttw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_out_free,
    input  ttw_pkg::t_stat i_stat,
    output logic          o_s_tready,
    output ttw_pkg::t_ctl o_ctl
);
    import ttw_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_COPY  = 7'b0000100,
        S_FLUSH = 7'b0001000,
        S_BLANK = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_ctl.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                if (i_stat.op == CMD_CLEAR) begin
                    o_ctl.sw_zero = 1'b1;
                    n_state       = S_CLEAR;
                end else if (i_stat.op == CMD_PUT && i_stat.scroll) begin
                    o_ctl.sw_zero = 1'b1;
                    n_state       = S_COPY;
                end else if (i_out_free) begin
                    o_ctl.out_load   = 1'b1;
                    o_ctl.res_direct = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_COPY: begin
                o_ctl.copy = 1'b1;
                if (i_stat.copy_last) begin
                    o_ctl.sw_tail = 1'b1;
                    n_state       = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_BLANK;
            end
            S_BLANK: begin
                o_ctl.blank = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                o_ctl.blank = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/ttw_datapath.sv
module ttw_datapath #(
    parameter int COLS     = ttw_pkg::DEF_COLS,
    parameter int ROWS     = ttw_pkg::DEF_ROWS,
    parameter int TAB_STEP = ttw_pkg::DEF_TAB_STEP
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ttw_pkg::t_ctl               i_ctl,
    input  logic [ttw_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ttw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_at_position,
    input  logic [ttw_pkg::POS_W-1:0]   i_col,
    input  logic [ttw_pkg::POS_W-1:0]   i_row,
    input  logic [ttw_pkg::IDX_W-1:0]   i_cell_index,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [ttw_pkg::ATTR_W-1:0]  i_cfg_data,
    output ttw_pkg::t_stat              o_stat,
    output ttw_pkg::t_res               o_res
);
    import ttw_pkg::*;

    localparam int NCELLS = COLS * ROWS;
    localparam int CW     = $clog2(NCELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int XW     = $clog2(COLS);
    localparam int WL     = $clog2(NCELLS + TAB_STEP + 1);
    localparam int WX     = $clog2(COLS + TAB_STEP);
    localparam int WY     = $clog2(ROWS + 2);

    localparam logic [CW-1:0] LAST_CELL  = CW'(NCELLS - 1);
    localparam logic [CW-1:0] TAIL_START = CW'(NCELLS - COLS);
    localparam logic [CW-1:0] COPY_LAST  = CW'(NCELLS - COLS - 1);

    // Attribute registers.
    logic [ATTR_W-1:0] r_text_color;
    logic [ATTR_W-1:0] r_error_color;

    // Latched item.
    t_cmd              r_op;
    logic [CHAR_W-1:0] r_ch;
    logic              r_at;
    logic              r_oob;
    logic              r_idx_ok;
    logic [WL-1:0]     r_tgt_lin;
    logic [RW-1:0]     r_tgt_row;
    logic [XW-1:0]     r_tgt_col;

    // Cursor, kept both linear and as row and column.
    logic [CW-1:0]     r_cur;
    logic [RW-1:0]     r_crow;
    logic [XW-1:0]     r_ccol;

    // Sweep and memory.
    logic [CW-1:0]     r_sw;
    logic              r_wpend;
    logic [CW-1:0]     r_wa;
    logic [CELL_W-1:0] r_rd_data;
    logic [CELL_W-1:0] mem [NCELLS];
    t_res              r_res;

    logic [31:0]       w_tgt_prod;
    logic [31:0]       w_idx_wide;
    logic [WL-1:0]     w_bl;
    logic [WY-1:0]     w_br;
    logic [WX-1:0]     w_bc;
    logic [WL-1:0]     w_ml;
    logic [WY-1:0]     w_mr;
    logic [WX-1:0]     w_mc;
    logic [WL-1:0]     w_fl;
    logic [WY-1:0]     w_fr;
    logic [WX-1:0]     w_fc;
    logic              w_scroll_raw;
    logic              w_go;
    logic              w_plain;
    logic [CW-1:0]     w_cur_after;
    logic [31:0]       w_cur_wide;
    t_res              w_res;
    logic              w_we;
    logic [CW-1:0]     w_wa;
    logic [CELL_W-1:0] w_wd;
    logic [CW-1:0]     w_ra;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color  <= TEXT_COLOR_RST;
            r_error_color <= ERROR_COLOR_RST;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                REG_TEXT_COLOR:  r_text_color  <= i_cfg_data;
                REG_ERROR_COLOR: r_error_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The target position is multiplied out when the beat is taken.
    assign w_tgt_prod = 32'(i_row) * COLS + 32'(i_col);
    assign w_idx_wide = 32'(i_cell_index);

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_op      <= t_cmd'(i_cmd);
            r_ch      <= i_char_code;
            r_at      <= i_at_position;
            r_oob     <= i_at_position &&
                         (32'(i_col) >= COLS || 32'(i_row) >= ROWS);
            r_idx_ok  <= w_idx_wide < NCELLS;
            r_tgt_lin <= w_tgt_prod[WL-1:0];
            r_tgt_row <= RW'(i_row);
            r_tgt_col <= XW'(i_col);
        end
    end

    assign w_bl = r_at ? WL'(r_tgt_lin) : WL'(r_cur);
    assign w_br = r_at ? WY'(r_tgt_row) : WY'(r_crow);
    assign w_bc = r_at ? WX'(r_tgt_col) : WX'(r_ccol);

    // Cursor motion for newline, tab and a written character.
    always_comb begin
        w_ml = w_bl;
        w_mr = w_br;
        w_mc = w_bc;
        case (r_ch)
            CH_NEWLINE: begin
                w_ml = w_bl - WL'(w_bc) + WL'(COLS);
                w_mr = w_br + WY'(1);
                w_mc = '0;
            end
            CH_TAB: begin
                w_ml = w_bl + WL'(TAB_STEP);
                w_mc = w_bc + WX'(TAB_STEP);
                // A tab step is at most twice the narrowest row.
                if (w_mc >= WX'(COLS)) begin
                    w_mc = w_mc - WX'(COLS);
                    w_mr = w_mr + WY'(1);
                end
                if (w_mc >= WX'(COLS)) begin
                    w_mc = w_mc - WX'(COLS);
                    w_mr = w_mr + WY'(1);
                end
            end
            default: begin
                w_ml = w_bl + WL'(1);
                w_mc = w_bc + WX'(1);
                if (w_mc == WX'(COLS)) begin
                    w_mc = '0;
                    w_mr = w_br + WY'(1);
                end
            end
        endcase
    end

    assign w_scroll_raw = w_ml >= WL'(NCELLS);

    always_comb begin
        w_fl = w_ml;
        w_fr = w_mr;
        w_fc = w_mc;
        if (w_scroll_raw) begin
            w_fl = w_ml - WL'(COLS);
            w_fr = w_mr - WY'(1);
            if (w_fl >= WL'(NCELLS)) begin
                w_fl = WL'(NCELLS - 1);
                w_fr = WY'(ROWS - 1);
                w_fc = WX'(COLS - 1);
            end
        end
    end

    assign w_go    = (r_op == CMD_PUT) && !r_oob;
    assign w_plain = (r_ch != CH_NEWLINE) && (r_ch != CH_TAB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_crow <= '0;
            r_ccol <= '0;
        end else if (i_ctl.exec) begin
            case (r_op)
                CMD_PUT: begin
                    if (!r_oob) begin
                        r_cur  <= CW'(w_fl);
                        r_crow <= RW'(w_fr);
                        r_ccol <= XW'(w_fc);
                    end
                end
                CMD_CLEAR: begin
                    r_cur  <= '0;
                    r_crow <= '0;
                    r_ccol <= '0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_op)
            CMD_PUT:   w_cur_after = r_oob ? r_cur : CW'(w_fl);
            CMD_CLEAR: w_cur_after = '0;
            default:   w_cur_after = r_cur;
        endcase
    end

    assign w_cur_wide = 32'(w_cur_after);

    always_comb begin
        w_res.cell_data     = (r_op == CMD_READ && r_idx_ok) ? r_rd_data : '0;
        w_res.cursor_index  = w_cur_wide[IDX_W-1:0];
        w_res.out_of_bounds = (r_op == CMD_PUT) && r_oob;
        w_res.scrolled      = w_go && w_scroll_raw;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_res <= w_res;
        end
    end

    assign o_res = i_ctl.res_direct ? w_res : r_res;

    always_comb begin
        o_stat.op        = r_op;
        o_stat.scroll    = w_go && w_scroll_raw;
        o_stat.copy_last = r_sw == COPY_LAST;
        o_stat.fill_last = r_sw == LAST_CELL;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sw_zero) begin
            r_sw <= '0;
        end else if (i_ctl.sw_tail) begin
            r_sw <= TAIL_START;
        end else if (i_ctl.copy || i_ctl.blank) begin
            r_sw <= r_sw + CW'(1);
        end
    end

    // A copy step reads one row ahead and writes the cell from the registered read data and address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpend <= 1'b0;
        end else begin
            r_wpend <= i_ctl.copy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa <= r_sw;
    end

    always_comb begin
        w_we = 1'b0;
        w_wa = r_wa;
        w_wd = r_rd_data;
        if (r_wpend) begin
            w_we = 1'b1;
        end else if (i_ctl.blank) begin
            w_we = 1'b1;
            w_wa = r_sw;
            w_wd = {r_text_color, CH_BLANK};
        end else if (i_ctl.exec && r_op == CMD_PUT && r_oob) begin
            w_we = 1'b1;
            w_wa = LAST_CELL;
            w_wd = {r_error_color, CH_ERR};
        end else if (i_ctl.exec && w_go && w_plain) begin
            w_we = 1'b1;
            w_wa = CW'(w_bl);
            w_wd = {r_text_color, r_ch};
        end
    end

    assign w_ra = i_ctl.copy ? (r_sw + CW'(COLS)) : w_idx_wide[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[w_ra];
    end

    a_exec_no_copy_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.exec |-> !r_wpend)
        else $error("single-cell write collides with a pending copy write");

    a_blank_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.blank |-> !r_wpend)
        else $error("blank write collides with a pending copy write");

    a_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < NCELLS)
        else $error("cursor beyond the last cell");

    a_cursor_coherent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) == 32'(r_crow) * COLS + 32'(r_ccol))
        else $error("linear cursor disagrees with row and column");

endmodule
